// ----- rtl/core/mmsp_pkg.sv -----
// ============================================================================
// mmsp_pkg
// Shared types, constants and controller command/status structs for the
// min-max streaming partitioner.
// ============================================================================
package mmsp_pkg;

    localparam int MAX_PARTITIONS_DEF     = 16;
    localparam int NUM_EDGES_DEF          = 4096;
    localparam int MAX_EDGES_PER_NODE_DEF = 64;
    localparam int MAX_NODES_DEF          = 65536;

    localparam int EDGE_W    = 12;
    localparam int NODE_W    = 16;
    localparam int PART_W    = 4;
    localparam int SHARED_W  = 7;
    localparam int SIZE_W    = 17;
    localparam int SLACK_W   = 16;
    localparam int NPART_W   = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTITIONS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SLACK     = 1'd1;

    localparam logic [NPART_W-1:0] NPART_RESET = 5'd2;
    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd12;
    localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = 17'h1FFFF;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_id;
        logic              last_edge;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]   node_index;
        logic [PART_W-1:0]   partition_id;
        logic [SHARED_W-1:0] shared_edges;
        logic                edge_overflow;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch input beat, start owner read
        logic count;     // add owner bits into shared counts, buffer edge
        logic min_init;  // start least-filled scan
        logic min_step;  // one partition of least-filled scan
        logic best_init; // start best-partition scan
        logic best_step; // one partition of best scan
        logic wb_rd;     // read buffered edge
        logic wb_own;    // read owner word of that edge
        logic wb_wr;     // write back owner word
        logic finish;    // update size, emit result, clear node state
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;      // latched beat was a node's last
        logic scan_done; // scan index reached the last active partition
        logic wb_done;   // write-back index reached the fill count
    } t_dp_sts;

endpackage

// ----- rtl/core/mmsp_ctrl.sv -----
// ============================================================================
// mmsp_ctrl
// Sequencer: per beat owner read and count, then at node end the least-filled
// scan, best-partition scan, owner write-back and result.
// ============================================================================
module mmsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mmsp_pkg::t_dp_sts i_sts,
    output logic              o_busy,
    output mmsp_pkg::t_dp_cmd o_cmd
);
    import mmsp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_COUNT = 9'b0_0000_0010,
        S_MIN   = 9'b0_0000_0100,
        S_BEST  = 9'b0_0000_1000,
        S_WBRD  = 9'b0_0001_0000,
        S_WBWR  = 9'b0_0010_0000,
        S_DONE  = 9'b0_0100_0000,
        S_MINI  = 9'b0_1000_0000,
        S_WBOW  = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_sts.last ? S_MINI : S_IDLE;
            end
            S_MINI: begin
                o_cmd.min_init = 1'b1;
                n_state        = S_MIN;
            end
            S_MIN: begin
                o_cmd.min_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_BEST;
                end
            end
            S_BEST: begin
                o_cmd.best_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_WBRD;
                end
            end
            S_WBRD: begin
                if (i_sts.wb_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wb_rd = 1'b1;
                    n_state     = S_WBOW;
                end
            end
            S_WBOW: begin
                o_cmd.wb_own = 1'b1;
                n_state      = S_WBWR;
            end
            S_WBWR: begin
                o_cmd.wb_wr = 1'b1;
                n_state     = S_WBRD;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // Best scan restarts its index when the min scan ends
        o_cmd.best_init = (r_state == S_MIN) && i_sts.scan_done;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/core/mmsp_datapath.sv -----
// ============================================================================
// mmsp_datapath
// Owner-bit memory, node edge buffer, shared counts, partition sizes and the
// serial min / best scans over partitions.
// ============================================================================
module mmsp_datapath #(
    parameter int MAX_PARTITIONS     = mmsp_pkg::MAX_PARTITIONS_DEF,
    parameter int NUM_EDGES          = mmsp_pkg::NUM_EDGES_DEF,
    parameter int MAX_EDGES_PER_NODE = mmsp_pkg::MAX_EDGES_PER_NODE_DEF,
    parameter int MAX_NODES          = mmsp_pkg::MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mmsp_pkg::t_in_item          i_item,
    input  logic                        i_cfg_we,
    input  logic [mmsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmsp_pkg::CFG_W-1:0]  i_cfg_data,
    input  mmsp_pkg::t_dp_cmd           i_cmd,
    output mmsp_pkg::t_dp_sts           o_sts,
    output logic                        o_done,
    output mmsp_pkg::t_out_item         o_result
);
    import mmsp_pkg::*;

    localparam int EA_W  = $clog2(NUM_EDGES);
    localparam int PI_W  = $clog2(MAX_PARTITIONS);
    localparam int BI_W  = (MAX_EDGES_PER_NODE > 1) ? $clog2(MAX_EDGES_PER_NODE) : 1;
    localparam int BF_W  = $clog2(MAX_EDGES_PER_NODE + 1);
    localparam int NC_W  = $clog2(MAX_NODES);
    localparam int CLR_W = EA_W + 1;

    // ---------------- configuration ----------------
    logic [NPART_W-1:0] r_npart;
    logic [SLACK_W-1:0] r_slack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npart <= NPART_RESET;
            r_slack <= SLACK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_PARTITIONS: r_npart <= i_cfg_data[NPART_W-1:0];
                REG_SIZE_SLACK:     r_slack <= i_cfg_data[SLACK_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to 2..MAX_PARTITIONS, as last index
    logic [PI_W-1:0] w_klast;
    always_comb begin
        if (r_npart < 5'd2) begin
            w_klast = PI_W'(1);
        end else if (32'(r_npart) > MAX_PARTITIONS) begin
            w_klast = PI_W'(MAX_PARTITIONS - 1);
        end else begin
            w_klast = PI_W'(r_npart - 5'd1);
        end
    end

    // ---------------- owner-bit memory ----------------
    // Clearing pass after reset: one word per cycle, through all NUM_EDGES words.
    logic [MAX_PARTITIONS-1:0] r_own_mem [NUM_EDGES];
    logic [MAX_PARTITIONS-1:0] r_own_rd;
    logic [CLR_W-1:0]          r_clr;
    logic                      w_clearing;
    assign w_clearing = !r_clr[EA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (w_clearing) begin
            r_clr <= r_clr + CLR_W'(1);
        end
    end

    // ---------------- edge buffer ----------------
    logic [EA_W-1:0] r_buf_mem [MAX_EDGES_PER_NODE];
    logic [EA_W-1:0] r_buf_rd;
    logic [BF_W-1:0] r_fill;
    logic [BF_W-1:0] r_wb_idx;
    logic            r_ovf;
    logic [EA_W-1:0] r_edge;
    logic            r_last;
    logic            w_room;
    assign w_room = (32'(r_fill) < MAX_EDGES_PER_NODE);

    logic [EA_W-1:0]           w_rd_addr;
    logic [MAX_PARTITIONS-1:0] w_wr_word;
    assign w_rd_addr = i_cmd.accept ? EA_W'(i_item.edge_id) : r_buf_rd;

    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_own_mem[r_clr[EA_W-1:0]] <= '0;
        end else if (i_cmd.wb_wr) begin
            r_own_mem[r_buf_rd] <= w_wr_word;
        end
        if (i_cmd.accept || i_cmd.wb_own) begin
            r_own_rd <= r_own_mem[w_rd_addr];
        end
        if (i_cmd.count && w_room) begin
            r_buf_mem[r_fill[BI_W-1:0]] <= r_edge;
        end
        if (i_cmd.wb_rd) begin
            r_buf_rd <= r_buf_mem[r_wb_idx[BI_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_edge <= EA_W'(i_item.edge_id);
            r_last <= i_item.last_edge;
        end
    end

    // ---------------- shared counts ----------------
    logic [SHARED_W-1:0] r_shared [MAX_PARTITIONS];
    logic [SIZE_W-1:0]   r_size   [MAX_PARTITIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_shared[p] <= '0;
            end
        end else if (i_cmd.finish) begin
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_shared[p] <= '0;
            end
        end else if (i_cmd.count && w_room) begin
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_shared[p] <= r_shared[p] + SHARED_W'(r_own_rd[p]);
            end
        end
    end

    // ---------------- scans ----------------
    logic [PI_W-1:0]     r_scan;
    logic [PI_W-1:0]     r_least;
    logic [SIZE_W:0]     r_bound;
    logic [PI_W-1:0]     r_best;
    logic [SHARED_W-1:0] r_best_cnt;
    logic [SIZE_W-1:0]   w_sz;
    assign w_sz = r_size[r_scan];

    always_ff @(posedge i_clk) begin
        if (i_cmd.min_init) begin
            r_scan  <= PI_W'(1);
            r_least <= '0;
        end else if (i_cmd.min_step) begin
            if (w_sz < r_size[r_least]) begin
                r_least <= r_scan;
            end
            r_scan <= i_cmd.best_init ? '0 : r_scan + PI_W'(1);
        end else if (i_cmd.best_step) begin
            if ((SIZE_W+1)'(w_sz) <= r_bound && r_shared[r_scan] > r_best_cnt) begin
                r_best     <= r_scan;
                r_best_cnt <= r_shared[r_scan];
            end
            r_scan <= r_scan + PI_W'(1);
        end
        if (i_cmd.best_init) begin
            // bound uses final least, including this step's compare
            if (w_sz < r_size[r_least]) begin
                r_bound <= (SIZE_W+1)'(w_sz) + (SIZE_W+1)'(r_slack);
                r_best  <= r_scan;
            end else begin
                r_bound <= (SIZE_W+1)'(r_size[r_least]) + (SIZE_W+1)'(r_slack);
                r_best  <= r_least;
            end
            r_best_cnt <= '0;
        end
    end

    // ---------------- write-back ----------------
    // wb_rd reads the buffer entry into r_buf_rd, wb_own reads the owner word
    // at that edge into r_own_rd, wb_wr writes it back with the chosen bit set.
    assign w_wr_word = r_own_rd | (MAX_PARTITIONS'(1) << r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_wb_idx <= '0;
        end else if (i_cmd.finish) begin
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_wb_idx <= '0;
        end else begin
            if (i_cmd.count) begin
                if (w_room) begin
                    r_fill <= r_fill + BF_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.wb_rd) begin
                r_wb_idx <= r_wb_idx + BF_W'(1);
            end
        end
    end

    // ---------------- sizes, counter, result ----------------
    logic [NC_W-1:0] r_node;
    logic            r_done;
    t_out_item       r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_size[p] <= '0;
            end
            r_node <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish) begin
                if (r_size[r_best] != SIZE_LIMIT) begin
                    r_size[r_best] <= r_size[r_best] + SIZE_W'(1);
                end
                r_node <= r_node + NC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.node_index    <= NODE_W'(r_node);
            r_result.partition_id  <= PART_W'(r_best);
            r_result.shared_edges  <= r_best_cnt;
            r_result.edge_overflow <= r_ovf;
        end
    end

    assign o_done        = r_done;
    assign o_result      = r_result;
    assign o_sts.last    = r_last;
    assign o_sts.scan_done = (r_scan == w_klast) && !w_clearing;
    assign o_sts.wb_done = (r_wb_idx == r_fill);

endmodule

// ----- rtl/core/minmax_stream_partitioner.sv -----
// ============================================================================
// minmax_stream_partitioner
// Streaming hypergraph partitioner: edges of a node in, one placement out
// per node.
// ============================================================================
//  channel   signals                         direction
//  input     i_start, o_busy, i_item         in  (beat when start & !busy)
//  result    o_valid, o_result               out (one-cycle strobe)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data in  (write, no wait)
//
//  A non-last edge is an owner read then a count. A last edge then runs the
//  serial least-filled and best-partition scans over the active partitions,
//  the single-port owner memory write-back of the buffered edges, and then
//  the result. After reset busy stays high while the owner memory is cleared.
//  The result is registered; the receiver cannot stall it.
module minmax_stream_partitioner #(
    parameter int MAX_PARTITIONS     = mmsp_pkg::MAX_PARTITIONS_DEF,
    parameter int NUM_EDGES          = mmsp_pkg::NUM_EDGES_DEF,
    parameter int MAX_EDGES_PER_NODE = mmsp_pkg::MAX_EDGES_PER_NODE_DEF,
    parameter int MAX_NODES          = mmsp_pkg::MAX_NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  mmsp_pkg::t_in_item             i_item,
    output logic                           o_valid,
    output mmsp_pkg::t_out_item            o_result,
    input  logic                           i_cfg_we,
    input  logic [mmsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmsp_pkg::CFG_W-1:0]     i_cfg_data
);
    import mmsp_pkg::*;

    localparam int CC_W = $clog2(NUM_EDGES) + 1;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ctrl_busy;
    logic    r_clr_busy;
    logic [CC_W-1:0] r_clr_cnt;

    // hold off beats during the owner memory clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + CC_W'(1);
            if (32'(r_clr_cnt) == NUM_EDGES - 1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    mmsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start && !r_clr_busy),
        .i_sts   (w_sts),
        .o_busy  (w_ctrl_busy),
        .o_cmd   (w_cmd)
    );

    mmsp_datapath #(
        .MAX_PARTITIONS     (MAX_PARTITIONS),
        .NUM_EDGES          (NUM_EDGES),
        .MAX_EDGES_PER_NODE (MAX_EDGES_PER_NODE),
        .MAX_NODES          (MAX_NODES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_done     (o_valid),
        .o_result   (o_result)
    );

    assign o_busy = w_ctrl_busy || r_clr_busy;

endmodule

// ----- rtl/core/mmsp_checker.sv -----
// ============================================================================
// mmsp_checker
// Port-level checks for the partitioner.
// ============================================================================
module mmsp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input mmsp_pkg::t_in_item  i_item,
    input logic                o_valid,
    input mmsp_pkg::t_out_item o_result
);
    import mmsp_pkg::*;

    // a non-last beat goes busy for exactly one cycle
    a_short_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_item.last_edge) |=> o_busy ##1 !o_busy)
        else $error("non-last beat held busy");

    // no result without a last-edge beat before it
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_item.last_edge) |=> !o_valid ##1 !o_valid)
        else $error("result after non-last beat");

    // result strobe is a single cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe stretched");

    // a last beat holds busy and gives no result in the next cycle
    a_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.last_edge) |=> o_busy && !o_valid)
        else $error("last beat not processed");

endmodule

bind minmax_stream_partitioner mmsp_checker u_mmsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);
